// ----- src/temporal_frame_average_assert.svh -----
// ----------------------------------------------------------------------------
// temporal_frame_average assertion macros
// Concurrent check macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_FRAME_AVERAGE_ASSERT_SVH
`define TEMPORAL_FRAME_AVERAGE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define TFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/tfa_pkg.sv -----
// ----------------------------------------------------------------------------
// tfa_pkg
// Fixed widths and shared types of the temporal frame averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfa_pkg;

	localparam int PIX_W     = 8;   // pixel byte
	localparam int CFG_W     = 17;  // frame size register
	localparam int IDX_W     = 16;  // reported pixel index
	localparam int SUM_W     = 32;  // per-pixel accumulator
	localparam int DIV_BITS  = 4;   // quotient bits per divider cycle
	localparam int DIV_STEPS = SUM_W / DIV_BITS;
	localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	// classification flags carried from front to back
	typedef struct packed {
		logic final_px;  // pixel of the final frame: produce an average
		logic last;      // pixel closes the frame
		logic dropped;   // frames of this set were ignored
	} cmd_flags_t;

	// one result transaction
	typedef struct packed {
		logic [PIX_W-1:0] average;
		logic [IDX_W-1:0] pixel_index;
		logic             last;
		logic             frames_dropped;
	} res_t;

	// back end status seen by the top level
	typedef struct packed {
		logic clearing;  // accumulator clear pass in progress
		logic div_idle;  // divider free for a new final pixel
	} back_status_t;

endpackage

// ----- src/tfa_fifo.sv -----
// ----------------------------------------------------------------------------
// tfa_fifo
// Small register FIFO used for the command queue and the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfa_fifo #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] din,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] dout,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] data_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- src/tfa_front.sv -----
// ----------------------------------------------------------------------------
// tfa_front
// Frame size register, position and frame counters; classifies each pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfa_front import tfa_pkg::*; #(
	parameter int MAX_PIXELS = 65536,
	parameter int MAX_FRAMES = 256,
	parameter int ADDR_W     = 16,
	parameter int SZ_W       = 17,
	parameter int FS_W       = 8,
	parameter int CNT_W      = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              accept,
	input  logic [PIX_W-1:0]  pixel,
	input  logic              final_frame,
	output logic              cmd_push,
	output logic [PIX_W-1:0]  cmd_pix,
	output logic [ADDR_W-1:0] cmd_addr,
	output logic [CNT_W-1:0]  cmd_cnt,
	output cmd_flags_t        cmd_flags
);

	localparam int SIZE_RST = (MAX_PIXELS < 65536) ? MAX_PIXELS : 65536;

	logic [SZ_W-1:0]   size_q;
	logic [ADDR_W-1:0] pos_q;
	logic [FS_W-1:0]   frames_q;
	logic              dropped_q;

	logic [SZ_W-1:0]   size_nxt;
	logic [ADDR_W-1:0] pos;
	logic [SZ_W-1:0]   pos_inc;
	logic              wrap;
	logic              capped;

	// clamp the written frame size into 1..MAX_PIXELS
	always_comb begin
		if (cfg_data == '0) begin
			size_nxt = SZ_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_PIXELS)) begin
			size_nxt = SZ_W'(MAX_PIXELS);
		end else begin
			size_nxt = SZ_W'(cfg_data);
		end
	end

	// position restarts when the frame shrank below it
	assign pos     = (SZ_W'(pos_q) >= size_q) ? '0 : pos_q;
	assign pos_inc = SZ_W'(pos) + 1'b1;
	assign wrap    = (pos_inc >= size_q);
	assign capped  = (frames_q == FS_W'(MAX_FRAMES - 1));

	assign cmd_push           = accept && (final_frame || !capped);
	assign cmd_pix            = pixel;
	assign cmd_addr           = pos;
	assign cmd_cnt            = CNT_W'(frames_q) + 1'b1;
	assign cmd_flags.final_px = final_frame;
	assign cmd_flags.last     = wrap;
	assign cmd_flags.dropped  = dropped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SZ_W'(SIZE_RST);
			pos_q     <= '0;
			frames_q  <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				size_q <= size_nxt;
			end
			if (accept) begin
				if (!final_frame && capped) begin
					dropped_q <= 1'b1;
				end
				if (wrap) begin
					pos_q <= '0;
					if (final_frame) begin
						frames_q  <= '0;
						dropped_q <= 1'b0;
					end else if (!capped) begin
						frames_q <= frames_q + 1'b1;
					end
				end else begin
					pos_q <= ADDR_W'(pos_inc);
				end
			end
		end
	end

endmodule

// ----- src/tfa_div.sv -----
// ----------------------------------------------------------------------------
// tfa_div
// Multi-cycle restoring divider, DIV_BITS quotient bits per clock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfa_div import tfa_pkg::*; #(
	parameter int CNT_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	input  res_t             meta,
	output logic             idle,
	output logic             res_push,
	output res_t             res,
	input  logic             res_full
);

	typedef enum logic [2:0] {
		DIV_IDLE = 3'b001,
		DIV_BUSY = 3'b010,
		DIV_DONE = 3'b100
	} div_state_t;

	div_state_t        state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  div_q;
	res_t              meta_q;

	logic [CNT_W-1:0]  rem_nxt;
	logic [SUM_W-1:0]  quo_nxt;

	// DIV_BITS shift-subtract steps; dividend bits leave at the top of quo,
	// quotient bits enter at the bottom
	always_comb begin
		logic [CNT_W:0] trial;
		rem_nxt = rem_q;
		quo_nxt = quo_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial   = {rem_nxt, quo_nxt[SUM_W-1]};
			quo_nxt = {quo_nxt[SUM_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_nxt    = CNT_W'(trial - {1'b0, div_q});
				quo_nxt[0] = 1'b1;
			end else begin
				rem_nxt = trial[CNT_W-1:0];
			end
		end
	end

	assign idle     = (state_q == DIV_IDLE);
	assign res_push = (state_q == DIV_DONE) && !res_full;

	always_comb begin
		res         = meta_q;
		res.average = quo_q[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				DIV_IDLE: begin
					if (start) begin
						state_q <= DIV_BUSY;
						step_q  <= '0;
					end
				end
				DIV_BUSY: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= DIV_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				DIV_DONE: begin
					if (!res_full) begin
						state_q <= DIV_IDLE;
					end
				end
				default: begin
					state_q <= DIV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			div_q  <= divisor;
			meta_q <= meta;
		end else if (state_q == DIV_BUSY) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

endmodule

// ----- src/tfa_back.sv -----
// ----------------------------------------------------------------------------
// tfa_back
// Accumulator memory, read-modify-write stage, clear pass and divider launch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfa_back import tfa_pkg::*; #(
	parameter int MAX_PIXELS = 65536,
	parameter int ADDR_W     = 16,
	parameter int CNT_W      = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	input  logic [PIX_W-1:0]  cmd_pix,
	input  logic [ADDR_W-1:0] cmd_addr,
	input  logic [CNT_W-1:0]  cmd_cnt,
	input  cmd_flags_t        cmd_flags,
	output logic              res_push,
	output res_t              res,
	input  logic              res_full,
	output back_status_t      status
);

	logic [SUM_W-1:0]  sum_mem_q [MAX_PIXELS];

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              v_s1;
	logic              fwd_s1;
	logic [SUM_W-1:0]  fwd_data_s1;
	logic [SUM_W-1:0]  rd_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [CNT_W-1:0]  cnt_s1;
	cmd_flags_t        flags_s1;

	logic              div_idle;
	logic              s1_adv;
	logic              div_start;
	logic [SUM_W-1:0]  total;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [SUM_W-1:0]  wr_data;
	res_t              meta;

	// stage 1 retires an add at once; a final pixel waits for the divider
	assign s1_adv    = v_s1 && (!flags_s1.final_px || div_idle);
	assign div_start = s1_adv && flags_s1.final_px;
	assign cmd_pop   = !clr_busy_q && cmd_valid && (!v_s1 || s1_adv);

	// a read issued while stage 1 writes the same entry sees the old word, so the written word is forwarded
	assign total = (fwd_s1 ? fwd_data_s1 : rd_s1) + SUM_W'(pix_s1);

	assign wr_en   = clr_busy_q || s1_adv;
	assign wr_addr = clr_busy_q ? clr_addr_q : addr_s1;
	assign wr_data = (clr_busy_q || flags_s1.final_px) ? '0 : total;

	assign meta.average        = '0;
	assign meta.pixel_index    = IDX_W'(addr_s1);
	assign meta.last           = flags_s1.last;
	assign meta.frames_dropped = flags_s1.dropped;

	assign status.clearing = clr_busy_q;
	assign status.div_idle = div_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			v_s1       <= 1'b0;
			fwd_s1     <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				if (clr_addr_q == ADDR_W'(MAX_PIXELS - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			if (cmd_pop) begin
				v_s1   <= 1'b1;
				fwd_s1 <= wr_en && (wr_addr == cmd_addr);
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			pix_s1      <= cmd_pix;
			addr_s1     <= cmd_addr;
			cnt_s1      <= cmd_cnt;
			flags_s1    <= cmd_flags;
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sum_mem_q[wr_addr] <= wr_data;
		end
		if (cmd_pop) begin
			rd_s1 <= sum_mem_q[cmd_addr];
		end
	end

	tfa_div #(
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total),
		.divisor  (cnt_s1),
		.meta     (meta),
		.idle     (div_idle),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full)
	);

endmodule

// ----- src/temporal_frame_average.sv -----
// ----------------------------------------------------------------------------
// temporal_frame_average
// Per-pixel mean over a set of frames. Pixels arrive in raster order through
// a queue-style push/full port; each pixel of a non-final frame is added into
// its accumulator at one pixel per clock sustained, unless the clear pass or a
// final pixel waiting for the divider holds the queue. A pixel flagged final is
// added too, its truncated mean (sum divided by frames counted plus one) is
// produced on the pop/empty side with its index, and its accumulator cleared.
// A final pixel waits in the read-modify-write stage until the shared divider
// (4 quotient bits per clock over a 32-bit sum) is idle, so no new final pixel
// is divided before the last result is queued. After reset the accumulator
// memory is zeroed one entry per clock over all MAX_PIXELS entries; the
// command queue takes 4 pixels during that pass and then holds full high. The
// frame size register is written through cfg_valid/cfg_ready (always ready);
// it must be written only while the block is idle, which the block itself
// does not enforce. A size of 0 means 1 and sizes above MAX_PIXELS mean
// MAX_PIXELS. Once MAX_FRAMES-1 frames have been counted, further non-final
// pixels are ignored and frames_dropped is reported on the results of the set.
`timescale 1ns / 1ps

module temporal_frame_average import tfa_pkg::*; #(
	parameter int MAX_PIXELS = 65536,
	parameter int MAX_FRAMES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	// frame size register write
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] frame_pixels,
	// pixel input transaction
	input  logic             push,
	output logic             full,
	input  logic [PIX_W-1:0] pixel,
	input  logic             final_frame,
	// result transaction
	output logic             empty,
	input  logic             pop,
	output logic [PIX_W-1:0] average,
	output logic [IDX_W-1:0] pixel_index,
	output logic             last,
	output logic             frames_dropped
);

	`include "temporal_frame_average_assert.svh"

	// position counter and accumulator address
	localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	// frame size, 1..MAX_PIXELS
	localparam int SZ_W   = $clog2(MAX_PIXELS + 1);
	// frames counted, 0..MAX_FRAMES-1
	localparam int FS_W   = $clog2(MAX_FRAMES);
	// divisor, 1..MAX_FRAMES
	localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
	localparam int CMD_W  = $bits(cmd_flags_t) + CNT_W + ADDR_W + PIX_W;
	localparam int RES_W  = $bits(res_t);

	// command queue between front and back
	logic              accept;
	logic              cmd_push;
	logic              cmd_full;
	logic              cmd_pop;
	logic              cmd_empty;
	logic [CMD_W-1:0]  cmd_din;
	logic [CMD_W-1:0]  cmd_dout;
	logic [PIX_W-1:0]  f_pix;
	logic [ADDR_W-1:0] f_addr;
	logic [CNT_W-1:0]  f_cnt;
	cmd_flags_t        f_flags;
	logic [PIX_W-1:0]  b_pix;
	logic [ADDR_W-1:0] b_addr;
	logic [CNT_W-1:0]  b_cnt;
	cmd_flags_t        b_flags;

	// result queue
	logic              res_push;
	logic              res_full;
	res_t              res_in;
	res_t              res_out;
	back_status_t      back_status;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full;
	// drops are absorbed by the front; the queue must still have room
	assign accept    = push && !cmd_full;

	assign cmd_din = {f_flags, f_cnt, f_addr, f_pix};
	assign {b_flags, b_cnt, b_addr, b_pix} = cmd_dout;

	assign average        = res_out.average;
	assign pixel_index    = res_out.pixel_index;
	assign last           = res_out.last;
	assign frames_dropped = res_out.frames_dropped;

	tfa_front #(
		.MAX_PIXELS (MAX_PIXELS),
		.MAX_FRAMES (MAX_FRAMES),
		.ADDR_W     (ADDR_W),
		.SZ_W       (SZ_W),
		.FS_W       (FS_W),
		.CNT_W      (CNT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (frame_pixels),
		.accept      (accept),
		.pixel       (pixel),
		.final_frame (final_frame),
		.cmd_push    (cmd_push),
		.cmd_pix     (f_pix),
		.cmd_addr    (f_addr),
		.cmd_cnt     (f_cnt),
		.cmd_flags   (f_flags)
	);

	tfa_fifo #(
		.DATA_W (CMD_W),
		.DEPTH  (4)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_din),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_dout),
		.empty  (cmd_empty)
	);

	tfa_back #(
		.MAX_PIXELS (MAX_PIXELS),
		.ADDR_W     (ADDR_W),
		.CNT_W      (CNT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd_pix   (b_pix),
		.cmd_addr  (b_addr),
		.cmd_cnt   (b_cnt),
		.cmd_flags (b_flags),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full),
		.status    (back_status)
	);

	tfa_fifo #(
		.DATA_W (RES_W),
		.DEPTH  (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	// front only enqueues when the input handshake saw room
	`TFA_ASSERT_IMP(a_cmd_no_overflow, clk, arst_n, cmd_push, !cmd_full, "command queue overflow")
	// divider holds its result while the result queue is full
	`TFA_ASSERT_IMP(a_res_no_overflow, clk, arst_n, res_push, !res_full, "result queue overflow")
	// no command may reach the accumulator before it is zeroed
	`TFA_ASSERT_IMP(a_no_pop_clearing, clk, arst_n, back_status.clearing, !cmd_pop,
		"command taken during clear pass")
	// a produced average becomes visible on the result side
	`TFA_ASSERT_NXT(a_res_visible, clk, arst_n, res_push, !empty, "result lost after push")

endmodule
